/* hw/rtl/sspg_pkg.sv */
package sspg_pkg;

   localparam int NUM_CH     = 4;
   localparam int CH_W       = 2;
   localparam int ANGLE_W    = 8;
   localparam int STEP_W     = 8;
   localparam int PULSE_W    = 15;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;

   // Slew arithmetic is done two bits wider so that current plus step cannot wrap.
   localparam int SLEW_W = ANGLE_W + 2;

   // Offset of the clamped angle from minus ninety degrees, 0..180.
   localparam int OFFSET_W  = 8;
   localparam int PRODUCT_W = OFFSET_W + PULSE_W;

   localparam logic signed [ANGLE_W-1:0] ANGLE_LO = -8'sd90;
   localparam logic signed [ANGLE_W-1:0] ANGLE_HI = 8'sd90;
   localparam logic [OFFSET_W-1:0]       OFFSET_FULL = 8'd180;

   // Division by 180 is a shift by two, then a multiply by ceil(2^27 / 45) and a shift by 27.
   // The result is exact for every dividend below 2^23.
   localparam int QUOT_N_W   = PRODUCT_W - 2;
   localparam int DIV_MULT_W = 22;
   localparam int DIV_SHIFT  = 27;
   localparam int DIV_FULL_W = QUOT_N_W + DIV_MULT_W;
   localparam logic [DIV_MULT_W-1:0] DIV_MULT = 22'd2982617;

   localparam logic [PULSE_W-1:0] PULSE_SAT = 15'd32767;

   localparam logic [STEP_W-1:0]  STEP_RESET      = 8'd1;
   localparam logic [PULSE_W-1:0] MIN_PULSE_RESET = 15'd500;
   localparam logic [PULSE_W-1:0] MAX_PULSE_RESET = 15'd2500;

   localparam logic signed [ANGLE_W-1:0] ANGLE_RESET     = 8'sd0;
   localparam logic signed [ANGLE_W-1:0] ANGLE_RESET_CH3 = 8'sd30;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PULSE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PULSE = 2'd2;

   localparam logic ACTION_SET_TARGET = 1'b0;
   localparam logic ACTION_TICK       = 1'b1;

   typedef struct packed {
      logic load_mul;
      logic load_out;
   } stage_ctl_type;

endpackage

/* hw/rtl/sspg_pulse_map.sv */
module sspg_pulse_map (
   input  logic                                    clock,
   input  sspg_pkg::stage_ctl_type                 ctl,
   input  logic signed [sspg_pkg::ANGLE_W-1:0]     angle,
   input  logic        [sspg_pkg::PULSE_W-1:0]     span,
   input  logic        [sspg_pkg::PULSE_W-1:0]     min_pulse,
   output logic        [sspg_pkg::PULSE_W-1:0]     pulse
);

   logic [sspg_pkg::OFFSET_W-1:0]   offset;
   logic signed [sspg_pkg::ANGLE_W:0] offset_wide;
   logic [sspg_pkg::PRODUCT_W-1:0]  product_in;
   logic [sspg_pkg::PRODUCT_W-1:0]  product_ff;
   logic [sspg_pkg::DIV_FULL_W-1:0] quot_full;
   logic [sspg_pkg::PULSE_W:0]      quot;
   logic [sspg_pkg::PULSE_W+1:0]    sum;
   logic [sspg_pkg::PULSE_W-1:0]    pulse_in;
   logic [sspg_pkg::PULSE_W-1:0]    pulse_ff;

   // Clamp to the mechanical range and shift so that minus ninety degrees is zero.
   always_comb begin
      offset_wide = {angle[sspg_pkg::ANGLE_W-1], angle}
                  - {sspg_pkg::ANGLE_LO[sspg_pkg::ANGLE_W-1], sspg_pkg::ANGLE_LO};
      if (angle < sspg_pkg::ANGLE_LO) begin
         offset = '0;
      end else if (angle > sspg_pkg::ANGLE_HI) begin
         offset = sspg_pkg::OFFSET_FULL;
      end else begin
         offset = offset_wide[sspg_pkg::OFFSET_W-1:0];
      end
      product_in = sspg_pkg::PRODUCT_W'(offset) * sspg_pkg::PRODUCT_W'(span);
   end

   always_comb begin
      quot_full = sspg_pkg::DIV_FULL_W'(product_ff[sspg_pkg::PRODUCT_W-1:2])
                * sspg_pkg::DIV_FULL_W'(sspg_pkg::DIV_MULT);
      quot      = quot_full[sspg_pkg::DIV_SHIFT +: (sspg_pkg::PULSE_W + 1)];
      sum       = {1'b0, quot} + {2'b00, min_pulse};
      if (sum > {2'b00, sspg_pkg::PULSE_SAT}) begin
         pulse_in = sspg_pkg::PULSE_SAT;
      end else begin
         pulse_in = sum[sspg_pkg::PULSE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_mul) begin
         product_ff <= product_in;
      end
      if (ctl.load_out) begin
         pulse_ff <= pulse_in;
      end
   end

   assign pulse = pulse_ff;

endmodule

/* hw/rtl/servo_slew_pulse_generator.sv */
// Pipeline: a transaction is accepted into the state update, then passes the span multiply
// and the divide and offset stages. Throughput: one transaction per cycle unless a stalled
// output backs up all three stages; they advance independently, so a bubble is filled even
// while a result waits at the output.
// Reset is synchronous: angles, step size and pulse limits return to their defaults.
module servo_slew_pulse_generator (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_action,
   input  logic        [sspg_pkg::CH_W-1:0]       req_channel,
   input  logic signed [sspg_pkg::ANGLE_W-1:0]    req_target_angle,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic        [sspg_pkg::PULSE_W-1:0]    rsp_pulse_ch0,
   output logic        [sspg_pkg::PULSE_W-1:0]    rsp_pulse_ch1,
   output logic        [sspg_pkg::PULSE_W-1:0]    rsp_pulse_ch2,
   output logic        [sspg_pkg::PULSE_W-1:0]    rsp_pulse_ch3,
   output logic                                   rsp_all_settled,
   input  logic                                   csr_wr_en,
   input  logic        [sspg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [sspg_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic [sspg_pkg::STEP_W-1:0]  step_ff;
   logic [sspg_pkg::PULSE_W-1:0] min_pulse_ff;
   logic [sspg_pkg::PULSE_W-1:0] max_pulse_ff;
   logic [sspg_pkg::PULSE_W-1:0] span;

   logic signed [sspg_pkg::ANGLE_W-1:0] cur_ff  [sspg_pkg::NUM_CH];
   logic signed [sspg_pkg::ANGLE_W-1:0] cur_in  [sspg_pkg::NUM_CH];
   logic signed [sspg_pkg::ANGLE_W-1:0] tgt_ff  [sspg_pkg::NUM_CH];
   logic signed [sspg_pkg::ANGLE_W-1:0] tgt_in  [sspg_pkg::NUM_CH];
   logic signed [sspg_pkg::ANGLE_W-1:0] snap_ff [sspg_pkg::NUM_CH];
   logic signed [sspg_pkg::SLEW_W-1:0]  cur_ext [sspg_pkg::NUM_CH];
   logic signed [sspg_pkg::SLEW_W-1:0]  tgt_ext [sspg_pkg::NUM_CH];
   logic signed [sspg_pkg::SLEW_W-1:0]  up_ext  [sspg_pkg::NUM_CH];
   logic signed [sspg_pkg::SLEW_W-1:0]  dn_ext  [sspg_pkg::NUM_CH];
   logic signed [sspg_pkg::SLEW_W-1:0]  step_ext;
   logic [sspg_pkg::PULSE_W-1:0]        pulse   [sspg_pkg::NUM_CH];

   logic settled_in;
   logic snap_settled_ff;
   logic mul_settled_ff;
   logic rsp_settled_ff;
   logic snap_valid_ff;
   logic mul_valid_ff;
   logic rsp_valid_ff;

   logic load_snap;
   logic load_mul;
   logic load_out;
   logic req_accept;
   sspg_pkg::stage_ctl_type ctl;

   // Each stage loads when the stage after it is empty or handing its transaction on.
   assign load_out   = !rsp_valid_ff || !rsp_stall;
   assign load_mul   = !mul_valid_ff || load_out;
   assign load_snap  = !snap_valid_ff || load_mul;
   assign req_stall  = !load_snap;
   assign req_accept = req_valid && load_snap;
   assign ctl.load_mul = load_mul;
   assign ctl.load_out = load_out;

   assign span = (max_pulse_ff >= min_pulse_ff) ? (max_pulse_ff - min_pulse_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= sspg_pkg::STEP_RESET;
         min_pulse_ff <= sspg_pkg::MIN_PULSE_RESET;
         max_pulse_ff <= sspg_pkg::MAX_PULSE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            sspg_pkg::CSR_STEP_SIZE: step_ff      <= csr_wdata[sspg_pkg::STEP_W-1:0];
            sspg_pkg::CSR_MIN_PULSE: min_pulse_ff <= csr_wdata[sspg_pkg::PULSE_W-1:0];
            sspg_pkg::CSR_MAX_PULSE: max_pulse_ff <= csr_wdata[sspg_pkg::PULSE_W-1:0];
            default: ;
         endcase
      end
   end

   assign step_ext = {{(sspg_pkg::SLEW_W - sspg_pkg::STEP_W){1'b0}}, step_ff};

   always_comb begin
      settled_in = 1'b1;
      for (int i = 0; i < sspg_pkg::NUM_CH; i++) begin
         cur_ext[i] = {{2{cur_ff[i][sspg_pkg::ANGLE_W-1]}}, cur_ff[i]};
         tgt_ext[i] = {{2{tgt_ff[i][sspg_pkg::ANGLE_W-1]}}, tgt_ff[i]};
         up_ext[i]  = cur_ext[i] + step_ext;
         dn_ext[i]  = cur_ext[i] - step_ext;
         cur_in[i]  = cur_ff[i];
         tgt_in[i]  = tgt_ff[i];
         if (req_action == sspg_pkg::ACTION_SET_TARGET) begin
            if (req_channel == sspg_pkg::CH_W'(i)) begin
               tgt_in[i] = req_target_angle;
            end
            if (cur_ff[i] != tgt_in[i]) begin
               settled_in = 1'b0;
            end
         end else begin
            // Pulses show a tick's move, the flag the state before; channels stop at targets.
            if (cur_ff[i] < tgt_ff[i]) begin
               settled_in = 1'b0;
               cur_in[i]  = (up_ext[i] > tgt_ext[i]) ? tgt_ff[i]
                                                     : up_ext[i][sspg_pkg::ANGLE_W-1:0];
            end else if (cur_ff[i] > tgt_ff[i]) begin
               settled_in = 1'b0;
               cur_in[i]  = (dn_ext[i] < tgt_ext[i]) ? tgt_ff[i]
                                                     : dn_ext[i][sspg_pkg::ANGLE_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sspg_pkg::NUM_CH; i++) begin
            cur_ff[i] <= (i == sspg_pkg::NUM_CH - 1) ? sspg_pkg::ANGLE_RESET_CH3
                                                    : sspg_pkg::ANGLE_RESET;
            tgt_ff[i] <= (i == sspg_pkg::NUM_CH - 1) ? sspg_pkg::ANGLE_RESET_CH3
                                                    : sspg_pkg::ANGLE_RESET;
         end
         snap_valid_ff <= 1'b0;
         mul_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_accept) begin
            for (int i = 0; i < sspg_pkg::NUM_CH; i++) begin
               cur_ff[i] <= cur_in[i];
               tgt_ff[i] <= tgt_in[i];
            end
         end
         if (load_snap) begin
            snap_valid_ff <= req_accept;
         end
         if (load_mul) begin
            mul_valid_ff <= snap_valid_ff;
         end
         if (load_out) begin
            rsp_valid_ff <= mul_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         for (int i = 0; i < sspg_pkg::NUM_CH; i++) begin
            snap_ff[i] <= cur_in[i];
         end
         snap_settled_ff <= settled_in;
      end
      if (load_mul) begin
         mul_settled_ff <= snap_settled_ff;
      end
      if (load_out) begin
         rsp_settled_ff <= mul_settled_ff;
      end
   end

   for (genvar g = 0; g < sspg_pkg::NUM_CH; g++) begin : g_ch
      sspg_pulse_map u_map (
         .clock     (clock),
         .ctl       (ctl),
         .angle     (snap_ff[g]),
         .span      (span),
         .min_pulse (min_pulse_ff),
         .pulse     (pulse[g])
      );
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pulse_ch0   = pulse[0];
   assign rsp_pulse_ch1   = pulse[1];
   assign rsp_pulse_ch2   = pulse[2];
   assign rsp_pulse_ch3   = pulse[3];
   assign rsp_all_settled = rsp_settled_ff;

   // An empty output stage lets the whole pipeline move.
   a_no_stall_when_out_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> !req_stall)
      else $error("input stalled while the output stage is empty");

   // A result only appears when the multiply stage held a transaction.
   a_rsp_from_pipeline: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(mul_valid_ff))
      else $error("result appeared without a transaction behind it");

   // A tick never carries a channel that lies below its target past it.
   for (genvar g = 0; g < sspg_pkg::NUM_CH; g++) begin : g_chk
      a_no_overshoot: assert property (@(posedge clock) disable iff (reset)
         (req_accept && req_action == sspg_pkg::ACTION_TICK && cur_ff[g] < tgt_ff[g])
         |=> (cur_ff[g] <= $past(tgt_ff[g]) && cur_ff[g] >= $past(cur_ff[g])))
         else $error("channel moved past its target");
   end

endmodule

/* dv/servo_slew_pulse_generator_tb.sv */
module servo_slew_pulse_generator_tb;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int HOLD_CYCLES     = 150;
   localparam int DRAIN_CYCLES    = 8;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 60;
   localparam int DEG_SPAN        = 180;
   localparam int MAX_PRINTED     = 40;
   localparam logic [sspg_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [sspg_pkg::NUM_CH-1:0][sspg_pkg::PULSE_W-1:0] pw;
      logic                                               settled;
   } pulse_set_type;

   typedef enum bit {ROW_REG, ROW_TXN} row_kind_type;

   typedef struct {
      row_kind_type                        kind;
      logic [sspg_pkg::CSR_IDX_W-1:0]      idx;
      logic [sspg_pkg::CSR_DATA_W-1:0]     data;
      logic                                action;
      logic [sspg_pkg::CH_W-1:0]           ch;
      logic signed [sspg_pkg::ANGLE_W-1:0] ang;
      bit                                  typed;
      pulse_set_type                       want;
   } dir_row_type;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic                                req_action;
   logic [sspg_pkg::CH_W-1:0]           req_channel;
   logic signed [sspg_pkg::ANGLE_W-1:0] req_target_angle;
   logic                                rsp_valid;
   logic                                rsp_stall;
   logic [sspg_pkg::PULSE_W-1:0]        rsp_pulse_ch0;
   logic [sspg_pkg::PULSE_W-1:0]        rsp_pulse_ch1;
   logic [sspg_pkg::PULSE_W-1:0]        rsp_pulse_ch2;
   logic [sspg_pkg::PULSE_W-1:0]        rsp_pulse_ch3;
   logic                                rsp_all_settled;
   logic                                csr_wr_en;
   logic [sspg_pkg::CSR_IDX_W-1:0]      csr_index;
   logic [sspg_pkg::CSR_DATA_W-1:0]     csr_wdata;

   // Shadow copy of the servo state and the registers.
   logic signed [sspg_pkg::ANGLE_W-1:0] cur_deg [sspg_pkg::NUM_CH];
   logic signed [sspg_pkg::ANGLE_W-1:0] tgt_deg [sspg_pkg::NUM_CH];
   logic [sspg_pkg::STEP_W-1:0]         slew_step;
   logic [sspg_pkg::PULSE_W-1:0]        pw_min;
   logic [sspg_pkg::PULSE_W-1:0]        pw_max;

   pulse_set_type                       pulse_q [$];
   dir_row_type                         dir_rows [$];
   int                                  err_count   = 0;
   int                                  rsp_seen    = 0;
   int                                  burst_left  = 0;
   int                                  cycle_count = 0;
   bit                                  hold_off_req = 1'b0;

   servo_slew_pulse_generator i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_channel      (req_channel),
      .req_target_angle (req_target_angle),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pulse_ch0    (rsp_pulse_ch0),
      .rsp_pulse_ch1    (rsp_pulse_ch1),
      .rsp_pulse_ch2    (rsp_pulse_ch2),
      .rsp_pulse_ch3    (rsp_pulse_ch3),
      .rsp_all_settled  (rsp_all_settled),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [sspg_pkg::PULSE_W-1:0] deg_to_pulse(
      logic signed [sspg_pkg::ANGLE_W-1:0] a);
      int d, lo, hi, span, p;
      d  = a;
      lo = pw_min;
      hi = pw_max;
      if (d < sspg_pkg::ANGLE_LO) d = sspg_pkg::ANGLE_LO;
      if (d > sspg_pkg::ANGLE_HI) d = sspg_pkg::ANGLE_HI;
      span = (hi >= lo) ? hi - lo : 0;
      p = (d - sspg_pkg::ANGLE_LO) * span / DEG_SPAN + lo;
      if (p > sspg_pkg::PULSE_SAT) p = sspg_pkg::PULSE_SAT;
      return p[sspg_pkg::PULSE_W-1:0];
   endfunction

   // Applies one transaction to the shadow state and returns the pulses it produces.
   function automatic pulse_set_type slew_servos(logic action, logic [sspg_pkg::CH_W-1:0] ch,
                                                 logic signed [sspg_pkg::ANGLE_W-1:0] ang);
      pulse_set_type res;
      int            c, t, stp;
      bit            still;
      still = 1'b1;
      stp   = slew_step;
      if (action == sspg_pkg::ACTION_SET_TARGET) begin
         tgt_deg[ch] = ang;
         for (int i = 0; i < sspg_pkg::NUM_CH; i++)
            if (cur_deg[i] != tgt_deg[i]) still = 1'b0;
      end else begin
         for (int i = 0; i < sspg_pkg::NUM_CH; i++) begin
            c = cur_deg[i];
            t = tgt_deg[i];
            if (c < t) begin
               c = c + stp;
               if (c > t) c = t;
               still = 1'b0;
            end else if (c > t) begin
               c = c - stp;
               if (c < t) c = t;
               still = 1'b0;
            end
            cur_deg[i] = c[sspg_pkg::ANGLE_W-1:0];
         end
      end
      for (int i = 0; i < sspg_pkg::NUM_CH; i++) res.pw[i] = deg_to_pulse(cur_deg[i]);
      res.settled = still;
      return res;
   endfunction

   function automatic void row_reg(logic [sspg_pkg::CSR_IDX_W-1:0] idx,
                                   logic [sspg_pkg::CSR_DATA_W-1:0] data);
      dir_row_type r;
      r.kind   = ROW_REG;
      r.idx    = idx;
      r.data   = data;
      r.action = sspg_pkg::ACTION_SET_TARGET;
      r.ch     = '0;
      r.ang    = '0;
      r.typed  = 1'b0;
      r.want   = '0;
      dir_rows.push_back(r);
   endfunction

   function automatic void row_txn(logic action, logic [sspg_pkg::CH_W-1:0] ch,
                                   logic signed [sspg_pkg::ANGLE_W-1:0] ang);
      dir_row_type r;
      r.kind   = ROW_TXN;
      r.idx    = '0;
      r.data   = '0;
      r.action = action;
      r.ch     = ch;
      r.ang    = ang;
      r.typed  = 1'b0;
      r.want   = '0;
      dir_rows.push_back(r);
   endfunction

   function automatic void row_txn_exp(logic action, logic [sspg_pkg::CH_W-1:0] ch,
                                       logic signed [sspg_pkg::ANGLE_W-1:0] ang,
                                       int p0, int p1, int p2, int p3, bit s);
      dir_row_type r;
      r.kind          = ROW_TXN;
      r.idx           = '0;
      r.data          = '0;
      r.action        = action;
      r.ch            = ch;
      r.ang           = ang;
      r.typed         = 1'b1;
      r.want.pw[0]    = p0[sspg_pkg::PULSE_W-1:0];
      r.want.pw[1]    = p1[sspg_pkg::PULSE_W-1:0];
      r.want.pw[2]    = p2[sspg_pkg::PULSE_W-1:0];
      r.want.pw[3]    = p3[sspg_pkg::PULSE_W-1:0];
      r.want.settled  = s;
      dir_rows.push_back(r);
   endfunction

   // The sender runs in bursts; a zero gap keeps valid high into the next transaction.
   function automatic int next_gap();
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      burst_left = $urandom_range(0, 20);
      return $urandom_range(1, 10);
   endfunction

   task automatic report_mismatch(string msg);
      err_count++;
      if (err_count <= MAX_PRINTED) $display("mismatch: %s", msg);
   endtask

   task automatic send_txn(logic action, logic [sspg_pkg::CH_W-1:0] ch,
                           logic signed [sspg_pkg::ANGLE_W-1:0] ang, bit typed,
                           pulse_set_type typed_val);
      int            gap;
      pulse_set_type pred;
      gap = next_gap();
      csr_wr_en <= 1'b0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= action;
      req_channel      <= ch;
      req_target_angle <= ang;
      do @(posedge clock); while (req_stall !== 1'b0);
      pred = slew_servos(action, ch, ang);
      pulse_q.push_back(typed ? typed_val : pred);
   endtask

   // Registers change only with the block drained.
   task automatic write_reg(logic [sspg_pkg::CSR_IDX_W-1:0] idx,
                            logic [sspg_pkg::CSR_DATA_W-1:0] data);
      req_valid <= 1'b0;
      while (pulse_q.size() != 0) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         sspg_pkg::CSR_STEP_SIZE: slew_step = data[sspg_pkg::STEP_W-1:0];
         sspg_pkg::CSR_MIN_PULSE: pw_min    = data;
         sspg_pkg::CSR_MAX_PULSE: pw_max    = data;
         default: ;
      endcase
   endtask

   initial begin : stimulus
      int                                  roll;
      logic [sspg_pkg::STEP_W-1:0]         stp;
      logic [sspg_pkg::PULSE_W-1:0]        lo, hi;
      logic                                act;
      logic [sspg_pkg::CH_W-1:0]           ch;
      logic signed [sspg_pkg::ANGLE_W-1:0] ang;

      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_action       <= sspg_pkg::ACTION_SET_TARGET;
      req_channel      <= '0;
      req_target_angle <= '0;
      csr_wr_en        <= 1'b0;
      csr_index        <= sspg_pkg::CSR_STEP_SIZE;
      csr_wdata        <= '0;

      slew_step = sspg_pkg::STEP_RESET;
      pw_min    = sspg_pkg::MIN_PULSE_RESET;
      pw_max    = sspg_pkg::MAX_PULSE_RESET;
      for (int i = 0; i < sspg_pkg::NUM_CH; i++) begin
         cur_deg[i] = sspg_pkg::ANGLE_RESET;
         tgt_deg[i] = sspg_pkg::ANGLE_RESET;
      end
      cur_deg[sspg_pkg::NUM_CH-1] = sspg_pkg::ANGLE_RESET_CH3;
      tgt_deg[sspg_pkg::NUM_CH-1] = sspg_pkg::ANGLE_RESET_CH3;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Out of reset channel three sits at thirty degrees, the rest at zero.
      row_txn_exp(sspg_pkg::ACTION_SET_TARGET, 2'd0, 8'sd0, 1500, 1500, 1500, 1833, 1'b1);
      row_txn_exp(sspg_pkg::ACTION_TICK, 2'd0, 8'sd0, 1500, 1500, 1500, 1833, 1'b1);
      row_txn_exp(sspg_pkg::ACTION_SET_TARGET, 2'd1, 8'sd90, 1500, 1500, 1500, 1833, 1'b0);
      row_txn(sspg_pkg::ACTION_TICK, 2'd3, -8'sd1);
      // Upper bits of the step write must be dropped.
      row_reg(sspg_pkg::CSR_STEP_SIZE, 15'h7FB4);
      row_txn(sspg_pkg::ACTION_SET_TARGET, 2'd2, 8'sh80);
      row_txn(sspg_pkg::ACTION_SET_TARGET, 2'd3, 8'sd127);
      row_txn(sspg_pkg::ACTION_SET_TARGET, 2'd0, -8'sd90);
      // Out-of-range targets are reached, but the mapping clamps them.
      row_txn_exp(sspg_pkg::ACTION_TICK, 2'd0, 8'sd0, 500, 2500, 500, 2500, 1'b0);
      row_txn_exp(sspg_pkg::ACTION_TICK, 2'd2, 8'sh7F, 500, 2500, 500, 2500, 1'b1);
      // With max below min every pulse collapses to min.
      row_reg(sspg_pkg::CSR_MIN_PULSE, 15'd20000);
      row_reg(sspg_pkg::CSR_MAX_PULSE, 15'd0);
      row_txn_exp(sspg_pkg::ACTION_TICK, 2'd1, 8'sd0, 20000, 20000, 20000, 20000, 1'b1);
      row_reg(sspg_pkg::CSR_MIN_PULSE, 15'd0);
      row_reg(sspg_pkg::CSR_MAX_PULSE, 15'h7FFF);
      row_txn_exp(sspg_pkg::ACTION_TICK, 2'd0, 8'sd0, 0, 32767, 0, 32767, 1'b1);
      row_reg(CSR_SPARE, 15'h7FFF);
      // A zero step freezes every channel but the flag still reports the mismatch.
      row_reg(sspg_pkg::CSR_STEP_SIZE, 15'h7F00);
      row_txn_exp(sspg_pkg::ACTION_SET_TARGET, 2'd0, 8'sd5, 0, 32767, 0, 32767, 1'b0);
      row_txn_exp(sspg_pkg::ACTION_TICK, 2'd0, 8'sd0, 0, 32767, 0, 32767, 1'b0);
      row_reg(sspg_pkg::CSR_STEP_SIZE, 15'd1);
      row_reg(sspg_pkg::CSR_MIN_PULSE, 15'd500);
      row_reg(sspg_pkg::CSR_MAX_PULSE, 15'd2500);
      row_txn(sspg_pkg::ACTION_TICK, 2'd2, 8'sd0);
      row_txn(sspg_pkg::ACTION_SET_TARGET, 2'd2, 8'sd127);
      row_txn(sspg_pkg::ACTION_SET_TARGET, 2'd1, -8'sd1);

      foreach (dir_rows[n]) begin
         if (dir_rows[n].kind == ROW_REG)
            write_reg(dir_rows[n].idx, dir_rows[n].data);
         else
            send_txn(dir_rows[n].action, dir_rows[n].ch, dir_rows[n].ang,
                     dir_rows[n].typed, dir_rows[n].want);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin stp = 8'd1;   lo = 15'd500;  hi = 15'd2500;   end
            1: begin stp = 8'd180; lo = 15'd0;    hi = 15'h7FFF;   end
            2: begin stp = 8'd0;   lo = 15'd1000; hi = 15'd2000;   end
            3: begin stp = 8'($urandom_range(1, 20)); lo = 15'd3000; hi = 15'd1000; end
            4: begin stp = 8'd255; lo = 15'h7FFF; hi = 15'h7FFF;   end
            default: begin
               stp = 8'($urandom_range(1, 40));
               lo  = 15'($urandom_range(0, 2000));
               hi  = 15'($urandom_range(0, 32767));
            end
         endcase
         write_reg(sspg_pkg::CSR_STEP_SIZE, {7'($urandom), stp});
         write_reg(sspg_pkg::CSR_MAX_PULSE, hi);
         write_reg(sspg_pkg::CSR_MIN_PULSE, lo);
         if (phase == 5) write_reg(CSR_SPARE, 15'($urandom));
         if (phase == 1) hold_off_req = 1'b1;

         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            ch = 2'($urandom);
            if ($urandom_range(0, 9) < 4) begin
               act  = sspg_pkg::ACTION_SET_TARGET;
               roll = $urandom_range(0, 19);
               if (roll < 2)
                  ang = 8'($urandom);
               else if (roll < 5)
                  ang = cur_deg[ch];
               else
                  ang = 8'($urandom_range(0, 180) - 90);
            end else begin
               act = sspg_pkg::ACTION_TICK;
               ang = 8'($urandom);
            end
            send_txn(act, ch, ang, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      csr_wr_en <= 1'b0;
      while (pulse_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0 && pulse_q.size() == 0)
         $display("servo_slew_pulse_generator regression: pass");
      else
         $display("servo_slew_pulse_generator regression: fail");
      $finish;
   end

   // The receiver picks stall patterns in runs; one long hold-off backs up the input.
   initial begin : rsp_pacer
      int mode, len;
      forever begin
         if (hold_off_req) begin
            for (int n = 0; n < HOLD_CYCLES; n++) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
            hold_off_req = 1'b0;
         end else begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(4, 40);
            for (int n = 0; n < len; n++) begin
               case (mode)
                  0:       rsp_stall <= 1'b0;
                  1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                  2:       rsp_stall <= (n % 3 != 0);
                  default: rsp_stall <= ($urandom_range(0, 3) != 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      pulse_set_type want, got;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got.pw[0]   = rsp_pulse_ch0;
         got.pw[1]   = rsp_pulse_ch1;
         got.pw[2]   = rsp_pulse_ch2;
         got.pw[3]   = rsp_pulse_ch3;
         got.settled = rsp_all_settled;
         if (pulse_q.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing expected", rsp_seen));
         end else begin
            want = pulse_q.pop_front();
            for (int c = 0; c < sspg_pkg::NUM_CH; c++)
               if (got.pw[c] !== want.pw[c])
                  report_mismatch($sformatf("result %0d pulse_ch%0d: expected %0d, got %0d",
                                            rsp_seen, c, want.pw[c], got.pw[c]));
            if (got.settled !== want.settled)
               report_mismatch($sformatf("result %0d all_settled: expected %0b, got %0b",
                                         rsp_seen, want.settled, got.settled));
         end
         rsp_seen++;
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("servo_slew_pulse_generator regression: fail");
      $finish;
   end

endmodule
